// ===== rtl/deap_double_ended_priority_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Deap queue assertion macros
// Concurrent assertion helpers that compile away under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DEAP_DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define DEAP_DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DEAP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("deap invariant violated");
`define DEAP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deap implication violated");
`else
`define DEAP_ASSERT_ALWAYS(label, clk, rst, cond)
`define DEAP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/deap_pkg.sv =====
// ----------------------------------------------------------------------------
// Deap queue package
// Shared types and constants of the double-ended heap job queue.
// ----------------------------------------------------------------------------
package deap_pkg;

   localparam int SLOT_W = 63;
   localparam logic [5:0] QUOTA_RESET = 6'd62;
   localparam int MIN_ROOT = 2;
   localparam int MAX_ROOT = 3;

   typedef struct packed {
      logic [30:0]        id;
      logic signed [31:0] prio;
   } slot_type;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_MAX  = 2'd1,
      FUNC_MIN  = 2'd2,
      FUNC_TRIM = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      EV_ADDED   = 2'd0,
      EV_PRINTED = 2'd1,
      EV_DROPPED = 2'd2,
      EV_EMPTY   = 2'd3
   } event_type;

endpackage

// ===== rtl/deap_intf.sv =====
// ----------------------------------------------------------------------------
// Deap queue channel interfaces
// Valid/ready channels for requests, responses and the quota register.
// ----------------------------------------------------------------------------
interface deap_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [30:0] job_id;
   logic signed [31:0] job_priority;
   modport source (output valid, func, job_id, job_priority, input ready);
   modport sink (input valid, func, job_id, job_priority, output ready);
endinterface

interface deap_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [30:0] job_id_res;
   logic [5:0]  job_count;
   logic        last;
   modport source (output valid, event_res, job_id_res, job_count, last, input ready);
   modport sink (input valid, event_res, job_id_res, job_count, last, output ready);
endinterface

interface deap_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/deap_ram.sv =====
// ----------------------------------------------------------------------------
// Deap generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module deap_ram #(
   parameter int WIDTH = 63,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/deap_double_ended_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Deap double-ended priority queue
// Bounded job queue kept as a deap in one RAM, with add, print, drop and trim.
// ----------------------------------------------------------------------------
//  channel  dir  transfers
//  req_ch   in   func, job_id, job_priority
//  rsp_ch   out  event_res, job_id_res, job_count, last
//  csr_ch   in   quota (always ready)
//
//  One request is taken at a time, only in the idle state. A removal reads
//  the root and, unless it holds the only job, the last entry, walks down the
//  deap level by level and then walks back up. An add at the quota first
//  drops the minimum job, and a trim runs one removal for every job it drops.
//  A result still waiting for its transfer holds the engine in its result
//  step. Reset is synchronous; afterwards the queue is empty and the quota
//  is 62.
// ----------------------------------------------------------------------------
`include "deap_double_ended_priority_queue_top_assert.svh"

module deap_double_ended_priority_queue_top #(
   parameter int CAPACITY = 62
) (
   input logic        clock,
   input logic        reset,
   deap_req_if.sink   req_ch,
   deap_rsp_if.source rsp_ch,
   deap_csr_if.sink   csr_ch
);

   localparam int DEPTH = CAPACITY + 2;
   localparam int AW = $clog2(DEPTH);
   localparam int IW = AW + 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > 6) ? CW : 6;

   typedef enum logic [4:0] {
      S_IDLE, S_RM0, S_RM1, S_RM2, S_SD, S_SD1, S_SD2, S_PL, S_PM,
      S_PXR, S_PX1, S_PX2, S_PXD, S_UP, S_UP1, S_INS, S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   deap_pkg::func_type     func_ff, func_in;
   deap_pkg::event_type    ev_ff, ev_in;
   deap_pkg::slot_type     job_ff, job_in;
   deap_pkg::slot_type     pl_ff, pl_in;
   deap_pkg::slot_type     a_ff, a_in;
   logic [30:0]            got_ff, got_in;
   logic [IW-1:0]          i_ff, i_in;
   logic [IW-1:0]          p_ff, p_in;
   logic [IW-1:0]          c_ff, c_in;
   logic [IW-1:0]          last_ff, last_in;
   logic                   up_max_ff, up_max_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [5:0]             quota_ff, quota_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   deap_pkg::event_type    rsp_event_ff, rsp_event_in;
   logic [30:0]            rsp_id_ff, rsp_id_in;
   logic [5:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en;
   logic [IW-1:0]          ram_wr_idx;
   deap_pkg::slot_type     ram_wr_slot;
   logic [IW-1:0]          ram_rd_idx;
   logic [deap_pkg::SLOT_W-1:0] ram_rd_data;
   deap_pkg::slot_type     rd_slot;

   logic [IW-1:0]          lay;
   logic                   is_max_half;
   logic [LW-1:0]          limit;
   logic [LW-1:0]          cnt_w;
   logic [LW-1:0]          quota_w;
   logic                   want_max;
   logic                   rsp_free;
   logic                   emit_last;
   logic                   rsp_empty_seen;
   logic                   rsp_added_seen;

   deap_ram #(
      .WIDTH(deap_pkg::SLOT_W),
      .DEPTH(DEPTH)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_idx[AW-1:0]),
      .wr_data(ram_wr_slot),
      .rd_addr(ram_rd_idx[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   assign rd_slot = deap_pkg::slot_type'(ram_rd_data);
   assign quota_w = LW'(quota_ff);
   assign cnt_w = LW'(count_ff);
   assign limit = (quota_w > LW'(CAPACITY)) ? LW'(CAPACITY) : quota_w;
   assign want_max = (func_ff == deap_pkg::FUNC_MAX);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_empty_seen = rsp_valid_ff && (rsp_event_ff == deap_pkg::EV_EMPTY);
   assign rsp_added_seen = rsp_valid_ff && (rsp_event_ff == deap_pkg::EV_ADDED);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.event_res = rsp_event_ff;
   assign rsp_ch.job_id_res = rsp_id_ff;
   assign rsp_ch.job_count = rsp_count_ff;
   assign rsp_ch.last = rsp_last_ff;

   always_comb begin
      lay = '0;
      is_max_half = 1'b0;
      for (int k = 1; k < IW; k++) begin
         if (i_ff[k]) begin
            lay = '0;
            lay[k-1] = 1'b1;
            is_max_half = i_ff[k-1];
         end
      end
   end

   always_comb begin
      case (func_ff)
         deap_pkg::FUNC_ADD:  emit_last = (ev_ff == deap_pkg::EV_ADDED);
         deap_pkg::FUNC_TRIM: emit_last = (cnt_w <= limit);
         default:             emit_last = 1'b1;
      endcase
   end

   always_comb begin
      logic [IW-1:0] pidx;
      logic [IW-1:0] cidx;
      logic [IW-1:0] cnt_idx;
      logic          sel;

      state_in = state_ff;
      func_in = func_ff;
      ev_in = ev_ff;
      job_in = job_ff;
      pl_in = pl_ff;
      a_in = a_ff;
      got_in = got_ff;
      i_in = i_ff;
      p_in = p_ff;
      c_in = c_ff;
      last_in = last_ff;
      up_max_in = up_max_ff;
      count_in = count_ff;
      quota_in = quota_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_event_in = rsp_event_ff;
      rsp_id_in = rsp_id_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in = rsp_last_ff;
      ram_wr_en = 1'b0;
      ram_wr_idx = i_ff;
      ram_wr_slot = pl_ff;
      ram_rd_idx = i_ff;
      pidx = '0;
      cidx = '0;
      cnt_idx = IW'(count_ff);
      sel = 1'b0;

      if (csr_ch.valid) begin
         quota_in = csr_ch.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               func_in = deap_pkg::func_type'(req_ch.func);
               job_in.id = req_ch.job_id;
               job_in.prio = req_ch.job_priority;
               unique case (deap_pkg::func_type'(req_ch.func))
                  deap_pkg::FUNC_ADD: begin
                     if (cnt_w >= limit && count_ff != '0) begin
                        ev_in = deap_pkg::EV_DROPPED;
                        state_in = S_RM0;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  deap_pkg::FUNC_MAX, deap_pkg::FUNC_MIN: begin
                     if (count_ff == '0) begin
                        ev_in = deap_pkg::EV_EMPTY;
                        state_in = S_EMIT;
                     end else begin
                        ev_in = (req_ch.func == deap_pkg::FUNC_MAX) ?
                                deap_pkg::EV_PRINTED : deap_pkg::EV_DROPPED;
                        state_in = S_RM0;
                     end
                  end
                  default: begin
                     if (cnt_w > limit) begin
                        ev_in = deap_pkg::EV_DROPPED;
                        state_in = S_RM0;
                     end
                  end
               endcase
            end
         end
         S_RM0: begin
            ram_rd_idx = (count_ff == CW'(1) || !want_max) ?
                         IW'(deap_pkg::MIN_ROOT) : IW'(deap_pkg::MAX_ROOT);
            state_in = S_RM1;
         end
         S_RM1: begin
            got_in = rd_slot.id;
            if (count_ff == CW'(1)) begin
               count_in = '0;
               state_in = S_EMIT;
            end else begin
               ram_rd_idx = cnt_idx + IW'(1);
               state_in = S_RM2;
            end
         end
         S_RM2: begin
            pl_in = rd_slot;
            count_in = count_ff - CW'(1);
            last_in = cnt_idx;
            i_in = want_max ? IW'(deap_pkg::MAX_ROOT) : IW'(deap_pkg::MIN_ROOT);
            if (want_max && cnt_idx == IW'(deap_pkg::MIN_ROOT)) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SD;
            end
         end
         S_SD: begin
            cidx = i_ff << 1;
            if (cidx <= last_ff) begin
               ram_rd_idx = cidx;
               c_in = cidx;
               state_in = S_SD1;
            end else begin
               state_in = S_PL;
            end
         end
         S_SD1: begin
            a_in = rd_slot;
            if (c_ff + IW'(1) <= last_ff) begin
               ram_rd_idx = c_ff + IW'(1);
               state_in = S_SD2;
            end else begin
               ram_wr_en = 1'b1;
               ram_wr_slot = rd_slot;
               i_in = c_ff;
               state_in = S_SD;
            end
         end
         S_SD2: begin
            sel = want_max ? ($signed(rd_slot.prio) > $signed(a_ff.prio)) :
                             ($signed(rd_slot.prio) < $signed(a_ff.prio));
            ram_wr_en = 1'b1;
            ram_wr_slot = sel ? rd_slot : a_ff;
            i_in = sel ? (c_ff + IW'(1)) : c_ff;
            state_in = S_SD;
         end
         S_PL: begin
            if (!is_max_half) begin
               pidx = i_ff + lay;
               if (pidx > last_ff) begin
                  pidx = pidx >> 1;
               end
               if (pidx < IW'(deap_pkg::MIN_ROOT)) begin
                  ram_wr_en = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  ram_rd_idx = pidx;
                  p_in = pidx;
                  state_in = S_PM;
               end
            end else begin
               pidx = i_ff - lay;
               cidx = pidx << 1;
               if (cidx <= last_ff) begin
                  ram_rd_idx = cidx;
                  c_in = cidx;
                  state_in = S_PX1;
               end else begin
                  ram_rd_idx = pidx;
                  p_in = pidx;
                  state_in = S_PXR;
               end
            end
         end
         S_PM: begin
            if ($signed(pl_ff.prio) > $signed(rd_slot.prio)) begin
               ram_wr_en = 1'b1;
               ram_wr_slot = rd_slot;
               i_in = p_ff;
               up_max_in = 1'b1;
            end else begin
               up_max_in = 1'b0;
            end
            state_in = S_UP;
         end
         S_PXR: begin
            a_in = rd_slot;
            state_in = S_PXD;
         end
         S_PX1: begin
            a_in = rd_slot;
            p_in = c_ff;
            if (c_ff + IW'(1) <= last_ff) begin
               ram_rd_idx = c_ff + IW'(1);
               state_in = S_PX2;
            end else begin
               state_in = S_PXD;
            end
         end
         S_PX2: begin
            if ($signed(rd_slot.prio) > $signed(a_ff.prio)) begin
               a_in = rd_slot;
               p_in = c_ff + IW'(1);
            end
            state_in = S_PXD;
         end
         S_PXD: begin
            if ($signed(pl_ff.prio) < $signed(a_ff.prio)) begin
               ram_wr_en = 1'b1;
               ram_wr_slot = a_ff;
               i_in = p_ff;
               up_max_in = 1'b0;
            end else begin
               up_max_in = 1'b1;
            end
            state_in = S_UP;
         end
         S_UP: begin
            if (i_ff > IW'(deap_pkg::MAX_ROOT)) begin
               ram_rd_idx = i_ff >> 1;
               state_in = S_UP1;
            end else begin
               ram_wr_en = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_UP1: begin
            sel = up_max_ff ? ($signed(rd_slot.prio) < $signed(pl_ff.prio)) :
                              ($signed(rd_slot.prio) > $signed(pl_ff.prio));
            ram_wr_en = 1'b1;
            if (sel) begin
               ram_wr_slot = rd_slot;
               i_in = i_ff >> 1;
               state_in = S_UP;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_INS: begin
            count_in = count_ff + CW'(1);
            ev_in = deap_pkg::EV_ADDED;
            pidx = cnt_idx + IW'(deap_pkg::MIN_ROOT);
            if (pidx == IW'(deap_pkg::MIN_ROOT)) begin
               ram_wr_en = 1'b1;
               ram_wr_idx = pidx;
               ram_wr_slot = job_ff;
               state_in = S_EMIT;
            end else begin
               i_in = pidx;
               last_in = pidx;
               pl_in = job_ff;
               state_in = S_PL;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = ev_ff;
               rsp_count_in = cnt_w[5:0];
               rsp_last_in = emit_last;
               case (ev_ff)
                  deap_pkg::EV_ADDED: rsp_id_in = job_ff.id;
                  deap_pkg::EV_EMPTY: rsp_id_in = '0;
                  default:            rsp_id_in = got_ff;
               endcase
               if (func_ff == deap_pkg::FUNC_ADD && ev_ff == deap_pkg::EV_DROPPED) begin
                  state_in = S_INS;
               end else if (!emit_last) begin
                  state_in = S_RM0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         quota_ff <= deap_pkg::QUOTA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         quota_ff <= quota_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      ev_ff <= ev_in;
      job_ff <= job_in;
      pl_ff <= pl_in;
      a_ff <= a_in;
      got_ff <= got_in;
      i_ff <= i_in;
      p_ff <= p_in;
      c_ff <= c_in;
      last_ff <= last_in;
      up_max_ff <= up_max_in;
      rsp_event_ff <= rsp_event_in;
      rsp_id_ff <= rsp_id_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff <= rsp_last_in;
   end

   `DEAP_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   `DEAP_ASSERT_IMPLY(a_wr_range, clock, reset, ram_wr_en, ram_wr_idx <= IW'(CAPACITY + 1))
   `DEAP_ASSERT_IMPLY(a_empty_count, clock, reset, rsp_empty_seen, rsp_count_ff == 6'd0)
   `DEAP_ASSERT_IMPLY(a_added_last, clock, reset, rsp_added_seen, rsp_last_ff)

endmodule

// ===== tb/sv/tb_deap_double_ended_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Deap queue testbench
// This testbench drives add, print, drop and trim requests and quota writes
// into the double-ended heap job queue. A model of the deap inside the
// testbench works out the expected responses, and every response transfer is
// checked field by field against them. A short directed table runs first.
// Random phases follow under several quota settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_deap_double_ended_priority_queue_top;

   localparam int CAP = 62;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 150;

   typedef struct {
      deap_pkg::event_type ev;
      logic [30:0]         id;
      logic [5:0]          cnt;
      logic                last;
   } job_event_type;

   typedef struct {
      logic                is_cfg;
      logic [5:0]          cfg;
      deap_pkg::func_type  func;
      logic [30:0]         id;
      logic signed [31:0]  prio;
      logic                chk;
      deap_pkg::event_type ev;
      logic [30:0]         xid;
      logic [5:0]          xcnt;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   deap_req_if req_ch ();
   deap_rsp_if rsp_ch ();
   deap_csr_if csr_ch ();

   deap_double_ended_priority_queue_top #(.CAPACITY(CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   deap_pkg::slot_type heap_img [0:CAP+1];
   int unsigned        held_jobs;
   int unsigned        quota_now;
   job_event_type      pending_events [$];
   job_event_type      lead_event;
   int                 lead_made;
   int                 fail_count;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 recv_idle_pct;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_deap_double_ended_priority_queue_top: FAIL");
         $finish;
      end
   end

   function automatic void sift_min_up(int unsigned i, deap_pkg::slot_type x);
      while (i > 3 && heap_img[i >> 1].prio > x.prio) begin
         heap_img[i] = heap_img[i >> 1];
         i = i >> 1;
      end
      heap_img[i] = x;
   endfunction

   function automatic void sift_max_up(int unsigned i, deap_pkg::slot_type x);
      while (i > 3 && heap_img[i >> 1].prio < x.prio) begin
         heap_img[i] = heap_img[i >> 1];
         i = i >> 1;
      end
      heap_img[i] = x;
   endfunction

   function automatic void settle_leaf(int unsigned i, int unsigned last_idx,
                                       deap_pkg::slot_type x);
      int unsigned t;
      int unsigned lay;
      int unsigned p;
      int unsigned c;
      t = i;
      lay = 1;
      while (t > 3) begin
         t = t >> 1;
         lay = lay << 1;
      end
      if (t == 2) begin
         p = i + lay;
         if (p > last_idx) p = p >> 1;
         if (p < 2) begin
            heap_img[i] = x;
         end else if (x.prio > heap_img[p].prio) begin
            heap_img[i] = heap_img[p];
            sift_max_up(p, x);
         end else begin
            sift_min_up(i, x);
         end
      end else begin
         p = i - lay;
         if (2 * p <= last_idx) begin
            c = 2 * p;
            if (c + 1 <= last_idx && heap_img[c + 1].prio > heap_img[c].prio) c++;
            p = c;
         end
         if (x.prio < heap_img[p].prio) begin
            heap_img[i] = heap_img[p];
            sift_min_up(p, x);
         end else begin
            sift_max_up(i, x);
         end
      end
   endfunction

   function automatic logic [30:0] take_end(bit want_max);
      int unsigned        last_idx;
      int unsigned        i;
      int unsigned        c;
      int unsigned        root;
      logic [30:0]        got;
      deap_pkg::slot_type x;
      last_idx = held_jobs + 1;
      if (held_jobs == 1) begin
         held_jobs = 0;
         return heap_img[2].id;
      end
      root = want_max ? deap_pkg::MAX_ROOT : deap_pkg::MIN_ROOT;
      got = heap_img[root].id;
      x = heap_img[last_idx];
      held_jobs--;
      last_idx--;
      if (root > last_idx) return got;
      i = root;
      while (2 * i <= last_idx) begin
         c = 2 * i;
         if (c + 1 <= last_idx) begin
            if (want_max ? (heap_img[c + 1].prio > heap_img[c].prio)
                         : (heap_img[c + 1].prio < heap_img[c].prio)) c++;
         end
         heap_img[i] = heap_img[c];
         i = c;
      end
      settle_leaf(i, last_idx, x);
      return got;
   endfunction

   function automatic void note_event(deap_pkg::event_type ev, logic [30:0] id);
      job_event_type e;
      e.ev = ev;
      e.id = id;
      e.cnt = held_jobs[5:0];
      e.last = 1'b0;
      pending_events = {pending_events, e};
   endfunction

   function automatic void predict_jobs(deap_pkg::func_type func, logic [30:0] id,
                                        logic signed [31:0] prio);
      int unsigned        limit;
      int                 n;
      deap_pkg::slot_type x;
      limit = (quota_now > CAP) ? CAP : quota_now;
      n = 0;
      if (func == deap_pkg::FUNC_ADD) begin
         x.id = id;
         x.prio = prio;
         if (held_jobs >= limit && held_jobs > 0) begin
            note_event(deap_pkg::EV_DROPPED, take_end(1'b0));
            n++;
         end
         if (held_jobs < CAP) begin
            held_jobs++;
            if (held_jobs == 1) heap_img[2] = x;
            else settle_leaf(held_jobs + 1, held_jobs + 1, x);
         end
         note_event(deap_pkg::EV_ADDED, id);
         n++;
      end else if (func == deap_pkg::FUNC_MAX || func == deap_pkg::FUNC_MIN) begin
         if (held_jobs == 0) begin
            note_event(deap_pkg::EV_EMPTY, '0);
         end else begin
            note_event(deap_pkg::event_type'(func), take_end(func == deap_pkg::FUNC_MAX));
         end
         n++;
      end else begin
         while (held_jobs > limit && n < CAP) begin
            note_event(deap_pkg::EV_DROPPED, take_end(1'b0));
            n++;
         end
      end
      if (n > 0) pending_events[$].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      job_event_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_events.size() == 0) begin
               $error("response transfer with no expected event");
               fail_count++;
            end else begin
               e = pending_events.pop_front();
               if (rsp_ch.event_res !== e.ev) begin
                  $error("event_res: expected %0d, actual %0d", e.ev, rsp_ch.event_res);
                  fail_count++;
               end
               if (rsp_ch.job_id_res !== e.id) begin
                  $error("job_id_res: expected %0d, actual %0d", e.id, rsp_ch.job_id_res);
                  fail_count++;
               end
               if (rsp_ch.job_count !== e.cnt) begin
                  $error("job_count: expected %0d, actual %0d", e.cnt, rsp_ch.job_count);
                  fail_count++;
               end
               if (rsp_ch.last !== e.last) begin
                  $error("last: expected %0d, actual %0d", e.last, rsp_ch.last);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic send_job(deap_pkg::func_type func, logic [30:0] id,
                           logic signed [31:0] prio);
      int base;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.job_id <= id;
      req_ch.job_priority <= prio;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      base = pending_events.size();
      predict_jobs(func, id, prio);
      lead_made = pending_events.size() - base;
      if (lead_made > 0) lead_event = pending_events[base];
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quota(logic [5:0] value);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      quota_now = value;
   endtask

   script_row_type script [] = '{
      '{0, 0, deap_pkg::FUNC_MIN, 0, 0, 1, deap_pkg::EV_EMPTY, 0, 0},
      '{0, 0, deap_pkg::FUNC_MAX, 0, 0, 1, deap_pkg::EV_EMPTY, 0, 0},
      '{0, 0, deap_pkg::FUNC_TRIM, 0, 0, 0, deap_pkg::EV_EMPTY, 0, 0},
      '{0, 0, deap_pkg::FUNC_ADD, 31'h7fffffff, 32'sh7fffffff, 1,
        deap_pkg::EV_ADDED, 31'h7fffffff, 1},
      '{0, 0, deap_pkg::FUNC_ADD, 0, 32'sh80000000, 1, deap_pkg::EV_ADDED, 0, 2},
      '{0, 0, deap_pkg::FUNC_ADD, 5, 0, 1, deap_pkg::EV_ADDED, 5, 3},
      '{0, 0, deap_pkg::FUNC_ADD, 6, -1, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_ADD, 7, 1, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_ADD, 8, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_ADD, 9, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_MAX, 0, 0, 1, deap_pkg::EV_PRINTED, 31'h7fffffff, 6},
      '{0, 0, deap_pkg::FUNC_MIN, 0, 0, 1, deap_pkg::EV_DROPPED, 0, 5},
      '{1, 2, deap_pkg::FUNC_ADD, 0, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_TRIM, 0, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_ADD, 10, 3, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_MAX, 0, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_MIN, 0, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{1, 0, deap_pkg::FUNC_ADD, 0, 0, 0, deap_pkg::EV_ADDED, 0, 0},
      '{0, 0, deap_pkg::FUNC_MIN, 0, 0, 1, deap_pkg::EV_EMPTY, 0, 0},
      '{0, 0, deap_pkg::FUNC_ADD, 11, 5, 1, deap_pkg::EV_ADDED, 11, 1},
      '{0, 0, deap_pkg::FUNC_ADD, 12, 6, 1, deap_pkg::EV_DROPPED, 11, 0},
      '{0, 0, deap_pkg::FUNC_TRIM, 0, 0, 1, deap_pkg::EV_DROPPED, 12, 0},
      '{1, 63, deap_pkg::FUNC_ADD, 0, 0, 0, deap_pkg::EV_ADDED, 0, 0}
   };

   initial begin
      int                 add_pct;
      int                 pick;
      deap_pkg::func_type func;
      logic [5:0]         phase_quota [6];
      phase_quota = '{6'd63, 6'd5, 6'd62, 6'd1, 6'd0, 6'd40};
      fail_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      held_jobs = 0;
      lead_made = 0;
      quota_now = deap_pkg::QUOTA_RESET;
      req_ch.valid = 1'b0;
      req_ch.func = deap_pkg::FUNC_ADD;
      req_ch.job_id = '0;
      req_ch.job_priority = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         if (script[r].is_cfg) begin
            write_quota(script[r].cfg);
         end else begin
            send_job(script[r].func, script[r].id, script[r].prio);
            if (script[r].chk && (lead_made <= 0
                  || lead_event.ev != script[r].ev
                  || lead_event.id != script[r].xid
                  || lead_event.cnt != script[r].xcnt)) begin
               $error("directed row %0d: model disagrees with table", r);
               fail_count++;
            end
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 61 : 0;
         recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 20 : 0;
         write_quota(phase_quota[ph]);
         add_pct = (phase_quota[ph] >= 62) ? 88 : 55;
         for (int k = 0; k < 30; k++) begin
            pick = $urandom_range(99);
            if (pick < add_pct) func = deap_pkg::FUNC_ADD;
            else if (pick < add_pct + (100 - add_pct) / 3) func = deap_pkg::FUNC_MAX;
            else if (pick < add_pct + 2 * (100 - add_pct) / 3) func = deap_pkg::FUNC_MIN;
            else func = deap_pkg::FUNC_TRIM;
            send_job(func, 31'($urandom), 32'($urandom));
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_events.size() == 0) begin
         $display("tb_deap_double_ended_priority_queue_top: PASS");
      end else begin
         $display("tb_deap_double_ended_priority_queue_top: FAIL");
      end
      $finish;
   end

endmodule
